[src/two_wire_adc_serial_master_assert.svh]
// assertion macros for the two-wire adc serial master
// included by the modules that carry concurrent checks; no other dependencies
`ifndef TWO_WIRE_ADC_SERIAL_MASTER_ASSERT_SVH
`define TWO_WIRE_ADC_SERIAL_MASTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TWADC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("twadc assertion failed");
// next-cycle implication
`define TWADC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("twadc assertion failed");
`else
`define TWADC_ASSERT_NOW(label, clk, rst, ante, cons)
`define TWADC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[src/twadc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the two-wire adc serial master
// no dependencies
package twadc_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int FRAME_CLOCKS = 46;
  localparam int CLK_IDX_W    = 6;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CLK_IDX_W-1:0] CONV_CLOCKS    = CLK_IDX_W'(SAMPLE_BITS + 3);
  localparam logic [CLK_IDX_W-1:0] CMD_CLOCKS     = CLK_IDX_W'(FRAME_CLOCKS);
  localparam logic [CLK_IDX_W-1:0] SAMPLE_LAST    = CLK_IDX_W'(SAMPLE_BITS);
  localparam logic [CLK_IDX_W-1:0] PRE_FIRST      = 6'd28;
  localparam logic [CLK_IDX_W-1:0] PRE_LAST       = 6'd29;
  localparam logic [CLK_IDX_W-1:0] CMDBIT_FIRST   = 6'd30;
  localparam logic [CLK_IDX_W-1:0] CMDBIT_LAST    = 6'd36;
  localparam logic [CLK_IDX_W-1:0] CMDBIT_HOLD    = 6'd37;
  localparam logic [CLK_IDX_W-1:0] BYTE_FIRST     = 6'd38;
  localparam logic [CLK_IDX_W-1:0] BYTE_LAST      = 6'd45;
  // bit index base for msb-first shifting: bit = base - clock
  localparam logic [CLK_IDX_W-1:0] CMDBIT_BASE    = 6'd37;
  localparam logic [CLK_IDX_W-1:0] BYTE_BASE      = 6'd45;

  localparam logic [7:0]  WRITE_CMD_BYTE      = 8'hCA;
  localparam logic [7:0]  READ_CMD_BYTE       = 8'hAC;
  localparam logic [15:0] HALF_PERIOD_RESET   = 16'd16;
  localparam logic [31:0] READY_TIMEOUT_RESET = 32'd15000000;

  localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_READY_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    CMD_CONV    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_READ    = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_PARKED = 5'b00010,
    PH_WAIT   = 5'b00100,
    PH_HIGH   = 5'b01000,
    PH_LOW    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       start_req;
    logic [1:0] action;
    logic [7:0] write_value;
    logic       dout_in;
  } item_t;

  typedef struct packed {
    logic                         sclk;
    logic                         dout_drive;
    logic                         dout_level;
    logic                         busy_res;
    logic                         done_res;
    logic                         status;
    logic signed [SAMPLE_BITS-1:0] conversion;
    logic [7:0]                   reg_value;
  } result_t;

endpackage

[src/twadc_in_stage.sv]
`timescale 1ns / 1ps
// input register: holds one tick word until the sequencer consumes it
// depends on twadc_pkg
module twadc_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  twadc_pkg::item_t      in_data,
  input  logic                  advance,
  output logic                  item_valid,
  output twadc_pkg::item_t      item
);

  logic take;

  assign in_stall = item_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= in_data;
    end
  end

endmodule

[src/twadc_seq.sv]
`timescale 1ns / 1ps
// bus sequencer: config registers, frame state and one-tick step logic
// depends on twadc_pkg and the assertion macro header
`include "two_wire_adc_serial_master_assert.svh"
module twadc_seq (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [twadc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [twadc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  step,
  input  twadc_pkg::item_t                      item,
  output twadc_pkg::result_t                    res
);

  logic [15:0] half_period;
  logic [31:0] ready_timeout;

  twadc_pkg::phase_t                    phase, phase_next;
  logic [twadc_pkg::CLK_IDX_W-1:0]      clock_index, clock_index_next;
  logic [15:0]                          half_count, half_count_next;
  logic [31:0]                          wait_count, wait_count_next;
  logic [twadc_pkg::SAMPLE_BITS-1:0]    rx_shift, rx_shift_next;
  logic [7:0]                           tx_shift, tx_shift_next;
  twadc_pkg::cmd_t                      cmd, cmd_next;

  logic [15:0]                          hp_eff;
  logic [31:0]                          tmo_eff;
  logic [15:0]                          half_inc;
  logic [31:0]                          wait_inc;
  logic [twadc_pkg::CLK_IDX_W-1:0]      clk_no;
  logic [twadc_pkg::CLK_IDX_W-1:0]      frame_len;
  logic [1:0]                           drive;
  logic [1:0]                           pin;

  // bit 1 drive, bit 0 level, for 1-based serial clock number
  function automatic logic [1:0] data_drive(twadc_pkg::cmd_t c_cmd,
                                            logic [twadc_pkg::CLK_IDX_W-1:0] c,
                                            logic [7:0] sbyte);
    logic [7:0] cmd_byte;
    logic [2:0] cbit;
    logic [2:0] dbit;
    logic [1:0] r;
    cmd_byte = (c_cmd == twadc_pkg::CMD_WRITE) ? twadc_pkg::WRITE_CMD_BYTE
                                               : twadc_pkg::READ_CMD_BYTE;
    cbit = 3'(twadc_pkg::CMDBIT_BASE - c);
    dbit = 3'(twadc_pkg::BYTE_BASE - c);
    r    = 2'b00;
    if (c_cmd == twadc_pkg::CMD_CONV) begin
      r = 2'b00;
    end else if (c >= twadc_pkg::CMDBIT_FIRST && c <= twadc_pkg::CMDBIT_LAST) begin
      r = {1'b1, cmd_byte[cbit]};
    end else if (c_cmd == twadc_pkg::CMD_WRITE) begin
      if (c == twadc_pkg::CMDBIT_HOLD) begin
        r = {1'b1, cmd_byte[1]};
      end else if (c >= twadc_pkg::BYTE_FIRST && c <= twadc_pkg::BYTE_LAST) begin
        r = {1'b1, sbyte[dbit]};
      end
    end else if (c == twadc_pkg::PRE_FIRST || c == twadc_pkg::PRE_LAST) begin
      r = 2'b11;
    end
    return r;
  endfunction

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period   <= twadc_pkg::HALF_PERIOD_RESET;
      ready_timeout <= twadc_pkg::READY_TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == twadc_pkg::REG_HALF_PERIOD) begin
        half_period <= cfg_data[15:0];
      end else if (cfg_index == twadc_pkg::REG_READY_TIMEOUT) begin
        ready_timeout <= cfg_data[31:0];
      end
    end
  end

  assign hp_eff    = (half_period == 16'd0) ? 16'd1 : half_period;
  assign tmo_eff   = (ready_timeout == 32'd0) ? 32'd1 : ready_timeout;
  assign half_inc  = half_count + 16'd1;
  assign wait_inc  = wait_count + 32'd1;
  assign clk_no    = clock_index + 6'd1;
  assign frame_len = (cmd == twadc_pkg::CMD_CONV) ? twadc_pkg::CONV_CLOCKS
                                                  : twadc_pkg::CMD_CLOCKS;
  assign drive     = data_drive(cmd, clk_no, tx_shift);

  always_comb begin
    phase_next       = phase;
    clock_index_next = clock_index;
    half_count_next  = half_count;
    wait_count_next  = wait_count;
    rx_shift_next    = rx_shift;
    tx_shift_next    = tx_shift;
    cmd_next         = cmd;
    pin              = 2'b00;
    res              = '0;
    unique case (phase)
      twadc_pkg::PH_WAIT: begin
        res.busy_res = 1'b1;
        if (!item.dout_in) begin
          phase_next       = twadc_pkg::PH_HIGH;
          clock_index_next = '0;
          half_count_next  = '0;
        end else begin
          wait_count_next = wait_inc;
          if (wait_inc >= tmo_eff) begin
            res.busy_res = 1'b0;
            res.done_res = 1'b1;
            res.status   = 1'b1;
            res.sclk     = 1'b1;
            pin          = 2'b11;
            phase_next   = twadc_pkg::PH_PARKED;
          end
        end
      end
      twadc_pkg::PH_HIGH: begin
        res.busy_res    = 1'b1;
        res.sclk        = 1'b1;
        pin             = drive;
        half_count_next = half_inc;
        if (half_inc >= hp_eff) begin
          if (cmd == twadc_pkg::CMD_CONV && clk_no <= twadc_pkg::SAMPLE_LAST) begin
            rx_shift_next = {rx_shift[twadc_pkg::SAMPLE_BITS-2:0], item.dout_in};
          end
          half_count_next = '0;
          phase_next      = twadc_pkg::PH_LOW;
        end
      end
      twadc_pkg::PH_LOW: begin
        res.busy_res    = 1'b1;
        pin             = drive;
        half_count_next = half_inc;
        if (half_inc >= hp_eff) begin
          if (cmd == twadc_pkg::CMD_READ && clk_no >= twadc_pkg::BYTE_FIRST &&
              clk_no <= twadc_pkg::BYTE_LAST) begin
            tx_shift_next = {tx_shift[6:0], item.dout_in};
          end
          half_count_next  = '0;
          clock_index_next = clk_no;
          if (clk_no >= frame_len) begin
            res.busy_res = 1'b0;
            res.done_res = 1'b1;
            phase_next   = twadc_pkg::PH_IDLE;
            if (cmd == twadc_pkg::CMD_CONV) begin
              res.conversion = rx_shift;
            end else if (cmd == twadc_pkg::CMD_READ) begin
              res.reg_value = tx_shift_next;
            end
          end else begin
            phase_next = twadc_pkg::PH_HIGH;
          end
        end
      end
      default: begin
        if (phase == twadc_pkg::PH_PARKED) begin
          res.sclk = 1'b1;
          pin      = 2'b11;
        end else begin
          phase_next = twadc_pkg::PH_IDLE;
        end
        if (item.start_req && item.action != twadc_pkg::CMD_UNKNOWN) begin
          cmd_next         = twadc_pkg::cmd_t'(item.action);
          tx_shift_next    = item.write_value;
          rx_shift_next    = '0;
          wait_count_next  = '0;
          clock_index_next = '0;
          half_count_next  = '0;
          phase_next       = twadc_pkg::PH_WAIT;
          res.busy_res     = 1'b1;
          res.sclk         = 1'b0;
          pin              = 2'b00;
        end
      end
    endcase
    res.dout_drive = pin[1];
    res.dout_level = pin[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= twadc_pkg::PH_IDLE;
      clock_index <= '0;
      half_count  <= '0;
      wait_count  <= '0;
      rx_shift    <= '0;
      tx_shift    <= '0;
      cmd         <= twadc_pkg::CMD_CONV;
    end else if (step) begin
      phase       <= phase_next;
      clock_index <= clock_index_next;
      half_count  <= half_count_next;
      wait_count  <= wait_count_next;
      rx_shift    <= rx_shift_next;
      tx_shift    <= tx_shift_next;
      cmd         <= cmd_next;
    end
  end

  `TWADC_ASSERT_NEXT(a_frame_end_idle, clk, rst, step && res.done_res && !res.status, phase == twadc_pkg::PH_IDLE)
  `TWADC_ASSERT_NEXT(a_timeout_parks, clk, rst, step && res.status, phase == twadc_pkg::PH_PARKED)
  `TWADC_ASSERT_NEXT(a_ready_starts_frame, clk, rst, step && phase == twadc_pkg::PH_WAIT && !item.dout_in, phase == twadc_pkg::PH_HIGH && clock_index == '0)
  `TWADC_ASSERT_NOW(a_index_in_frame, clk, rst, phase == twadc_pkg::PH_HIGH || phase == twadc_pkg::PH_LOW, clock_index < twadc_pkg::CMD_CLOCKS)

endmodule

[src/twadc_out_stage.sv]
`timescale 1ns / 1ps
// output register: holds one result word until the consumer takes it
// depends on twadc_pkg
module twadc_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  twadc_pkg::result_t    res,
  output logic                  out_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output twadc_pkg::result_t    out_data
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

[src/two_wire_adc_serial_master.sv]
`timescale 1ns / 1ps
// top level of the two-wire sigma-delta adc serial master
// depends on twadc_pkg, twadc_in_stage, twadc_seq and twadc_out_stage
//
//   channel   direction  handshake           word
//   in        sink       in_valid/in_stall   twadc_pkg::item_t, one system tick
//   out       source     out_valid/out_stall twadc_pkg::result_t, pin levels and status
//   cfg       sink       cfg_we              cfg_index selects, cfg_data carries value
//
// one word per cycle sustained while the output is not stalled: each tick word goes
// input register -> step logic -> output register
// the step logic (one 32-bit add and compare for the ready timeout) sets the path
// a stalled output holds its word; the input register keeps taking until it is full
// reset clears the handshake flags, the frame state and loads the default
// half period (16) and ready timeout (15000000)
module two_wire_adc_serial_master (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  twadc_pkg::item_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output twadc_pkg::result_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [twadc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [twadc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic               item_valid;
  twadc_pkg::item_t   item;
  twadc_pkg::result_t res;
  logic               out_free;
  logic               advance;

  // a word moves on when one is waiting and the output slot frees up this cycle
  assign advance = item_valid && out_free;

  twadc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // sequencer state only moves on consumed words, so stalls never skip a tick
  twadc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (item),
    .res       (res)
  );

  twadc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
